// ===== rtl/lcdns_pkg.sv =====
// Shared types and constants for the character LCD nibble sequencer.
// Used by the front end, the request queue, the back end and the top level.
package lcdns_pkg;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_CMD    = 2'd1,
        OP_DATA   = 2'd2,
        OP_CURSOR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_FUNCTION_SET = 2'd0,
        CFG_DISPLAY_CTRL = 2'd1,
        CFG_ENTRY_MODE   = 2'd2
    } t_cfg_idx;

    localparam logic [7:0] FUNCTION_SET_RST = 8'h28;
    localparam logic [7:0] DISPLAY_CTRL_RST = 8'h0E;
    localparam logic [7:0] ENTRY_MODE_RST   = 8'h06;

    localparam logic [7:0] DDRAM_ROW1 = 8'h80;
    localparam logic [7:0] DDRAM_ROW2 = 8'hC0;
    localparam logic [7:0] CLEAR_CMD  = 8'h01;
    localparam logic [7:0] HOME_LAST  = 8'h03;

    localparam logic [3:0] WAKE_NIB   = 4'h3;
    localparam logic [3:0] WIDTH4_NIB = 4'h2;

    localparam logic [15:0] POWER_UP_WAIT_US   = 16'd40000;
    localparam logic [12:0] WAKE_WAIT_1_US     = 13'd5000;
    localparam logic [12:0] WAKE_WAIT_2_US     = 13'd150;
    localparam logic [12:0] CLEAR_HOME_WAIT_US = 13'd2000;

    // init: four wake nibbles, then four bytes of two nibbles each
    localparam int          INIT_XFERS = 12;
    localparam int          STEP_W     = $clog2(INIT_XFERS);
    localparam logic [STEP_W-1:0] WAKE_LAST_STEP = STEP_W'(3);
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = STEP_W'(INIT_XFERS - 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // one queued request for the back end
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] value;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_qhead;

    typedef struct packed {
        logic [7:0] function_set;
        logic [7:0] display_ctrl;
        logic [7:0] entry_mode;
    } t_cfg;

endpackage

// ===== rtl/lcdns_front.sv =====
// Front end: accepts requests and turns them into queue descriptors.
// Depends on lcdns_pkg. Cursor sets with an invalid row are dropped here.
module lcdns_front (
    input  logic               i_valid,
    input  logic               i_q_full,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_byte_value,
    input  logic [1:0]         i_row,
    input  logic [4:0]         i_column,
    output logic               o_stall,
    output logic               o_push,
    output lcdns_pkg::t_desc   o_desc
);
    import lcdns_pkg::*;

    logic       accept;
    logic       keep;
    logic [7:0] offset;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    // column 0 wraps to 0xFF, as the address byte is 8 bits
    assign offset  = 8'({3'b000, i_column} - 8'd1);

    always_comb begin
        keep           = 1'b1;
        o_desc.is_init = 1'b0;
        o_desc.rs      = 1'b0;
        o_desc.value   = i_byte_value;
        case (i_operation)
            OP_INIT: begin
                o_desc.is_init = 1'b1;
            end
            OP_CMD: begin
                o_desc.rs = 1'b0;
            end
            OP_DATA: begin
                o_desc.rs = 1'b1;
            end
            OP_CURSOR: begin
                if (i_row == 2'd1) begin
                    o_desc.value = DDRAM_ROW1 | offset;
                end else if (i_row == 2'd2) begin
                    o_desc.value = DDRAM_ROW2 | offset;
                end else begin
                    keep = 1'b0;
                end
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = accept && keep;

endmodule

// ===== rtl/lcdns_queue.sv =====
// Short descriptor queue between the front end and the back end.
// Depends on lcdns_pkg for the descriptor type and depth.
module lcdns_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lcdns_pkg::t_desc   i_desc,
    input  logic               i_pop,
    output logic               o_full,
    output lcdns_pkg::t_qhead  o_head
);
    import lcdns_pkg::*;

    t_desc              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]    r_count, n_count;
    logic               do_pop;

    assign o_full      = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.desc  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// ===== rtl/lcdns_back.sv =====
// Back end: expands the queue head into nibble transfers, one per cycle
// unless stalled, into a registered output stage. Depends on lcdns_pkg.
module lcdns_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcdns_pkg::t_qhead  i_head,
    input  lcdns_pkg::t_cfg    i_cfg,
    input  logic               i_stall,
    output logic               o_pop,
    output logic               o_valid,
    output logic               o_reg_select,
    output logic [3:0]         o_nibble,
    output logic [15:0]        o_wait_before_us,
    output logic [12:0]        o_wait_after_us,
    output logic               o_last
);
    import lcdns_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic              advance;
    logic              hi_half;
    logic [1:0]        byte_sel;
    logic [7:0]        cur_byte;
    logic              xfer_rs;
    logic [3:0]        xfer_nib;
    logic [15:0]       xfer_before;
    logic [12:0]       xfer_after;
    logic              xfer_last;
    logic              clear_home;

    assign advance = !o_valid || !i_stall;
    assign hi_half = !r_step[0];
    // init bytes start at step 4: steps 4,5 -> 0, 6,7 -> 1, 8,9 -> 2, 10,11 -> 3
    assign byte_sel = 2'(r_step[2:1] + 2'd2);

    always_comb begin
        cur_byte = i_head.desc.value;
        if (i_head.desc.is_init) begin
            case (byte_sel)
                2'd0:    cur_byte = i_cfg.function_set;
                2'd1:    cur_byte = i_cfg.display_ctrl;
                2'd2:    cur_byte = CLEAR_CMD;
                default: cur_byte = i_cfg.entry_mode;
            endcase
        end
    end

    assign clear_home = !xfer_rs && !hi_half &&
                        (cur_byte >= CLEAR_CMD) && (cur_byte <= HOME_LAST);

    always_comb begin
        xfer_rs     = i_head.desc.is_init ? 1'b0 : i_head.desc.rs;
        xfer_nib    = hi_half ? cur_byte[7:4] : cur_byte[3:0];
        xfer_before = '0;
        xfer_after  = clear_home ? CLEAR_HOME_WAIT_US : '0;
        xfer_last   = r_step[0];
        if (i_head.desc.is_init) begin
            xfer_last = (r_step == INIT_LAST_STEP);
            if (r_step <= WAKE_LAST_STEP) begin
                xfer_nib   = (r_step == WAKE_LAST_STEP) ? WIDTH4_NIB : WAKE_NIB;
                xfer_after = '0;
                if (r_step == '0) begin
                    xfer_before = POWER_UP_WAIT_US;
                    xfer_after  = WAKE_WAIT_1_US;
                end else if (r_step == STEP_W'(1)) begin
                    xfer_after  = WAKE_WAIT_2_US;
                end
            end
        end
    end

    assign o_pop = advance && i_head.valid && xfer_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_step  <= '0;
        end else if (advance) begin
            o_valid <= i_head.valid;
            if (i_head.valid) begin
                r_step <= xfer_last ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_head.valid) begin
            o_reg_select     <= xfer_rs;
            o_nibble         <= xfer_nib;
            o_wait_before_us <= xfer_before;
            o_wait_after_us  <= xfer_after;
            o_last           <= xfer_last;
        end
    end

endmodule

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// Character LCD nibble sequencer, top level.
// Depends on lcdns_pkg, lcdns_front, lcdns_queue and lcdns_back.
//
// Request channel (i_valid / o_stall): operation, byte, row and column.
// A transfer happens at a clock edge with i_valid high and o_stall low.
// Result channel (o_valid / i_stall): one nibble transfer per item, with
// register select, waits around the enable pulse, and o_last on the final
// transfer of the request. The enable pulse itself (10 us high, 100 us
// settle) is timed by the bus driver downstream.
// Command, data and cursor requests give 2 transfers, init gives 12, and a
// cursor set with row 0 or 3 is accepted and gives none.
// A request is written into the queue, and its first transfer is then
// registered in the back end output stage; the back end emits one transfer
// per cycle unless stalled, its step counter walking the queue head.
// A 4-entry queue lets requests be taken while the back end is busy or the
// receiver stalls; o_stall rises only when that queue is full. A stalled
// result holds its value.
// Config registers (write port, always ready) may be written when idle.
// Reset clears the queue and output valid and restores the register defaults.
module char_lcd_nibble_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_byte_value,
    input  logic [1:0]  i_row,
    input  logic [4:0]  i_column,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_reg_select,
    output logic [3:0]  o_nibble,
    output logic [15:0] o_wait_before_us,
    output logic [12:0] o_wait_after_us,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import lcdns_pkg::*;

    t_cfg   r_cfg;
    t_desc  front_desc;
    t_qhead q_head;
    logic   push;
    logic   pop;
    logic   q_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.function_set <= FUNCTION_SET_RST;
            r_cfg.display_ctrl <= DISPLAY_CTRL_RST;
            r_cfg.entry_mode   <= ENTRY_MODE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FUNCTION_SET: r_cfg.function_set <= i_cfg_data;
                CFG_DISPLAY_CTRL: r_cfg.display_ctrl <= i_cfg_data;
                CFG_ENTRY_MODE:   r_cfg.entry_mode   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lcdns_front u_front (
        .i_valid      (i_valid),
        .i_q_full     (q_full),
        .i_operation  (i_operation),
        .i_byte_value (i_byte_value),
        .i_row        (i_row),
        .i_column     (i_column),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_desc       (front_desc)
    );

    lcdns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    lcdns_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (q_head),
        .i_cfg            (r_cfg),
        .i_stall          (i_stall),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_reg_select     (o_reg_select),
        .o_nibble         (o_nibble),
        .o_wait_before_us (o_wait_before_us),
        .o_wait_after_us  (o_wait_after_us),
        .o_last           (o_last)
    );

endmodule

// ===== rtl/lcdns_checker.sv =====
// Port-level checks for the character LCD nibble sequencer.
// Bound to char_lcd_nibble_sequencer; sees its ports only.
module lcdns_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_stall,
    input logic        o_valid,
    input logic        o_reg_select,
    input logic [3:0]  o_nibble,
    input logic [15:0] o_wait_before_us,
    input logic [12:0] o_wait_after_us,
    input logic        o_last
);

    // held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_nibble) &&
        $stable(o_reg_select) && $stable(o_last) && $stable(o_wait_after_us))
        else $error("stalled transfer changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // power-up wait only on the first wake nibble of init
    a_power_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_wait_before_us != 16'd0) |->
        (o_nibble == 4'h3) && !o_reg_select && !o_last &&
        (o_wait_after_us == 13'd5000))
        else $error("power-up wait on wrong transfer");

    // second wake nibble follows at once, unless stalled, with the short wait
    a_wake_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_wait_before_us != 16'd0) |=>
        o_valid && (o_nibble == 4'h3) && (o_wait_after_us == 13'd150))
        else $error("wake sequence broken");

    a_data_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reg_select |-> (o_wait_after_us == 13'd0) &&
        (o_wait_before_us == 16'd0))
        else $error("wait on data transfer");

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (.*);
